// File: hdl/drp_pkg.sv
package drp_pkg;

  localparam int RING_ENTRIES_DEF = 512;
  localparam int SLOT_W = 9;
  localparam int LIMIT_W = 14;
  localparam int BASE_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd1792;

  typedef enum logic [1:0] {
    STATUS_WRITTEN  = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_RING = 2'd2,
    STATUS_RELEASED = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RING_ZERO_BASE = 2'd0,
    CFG_RING_ONE_BASE  = 2'd1,
    CFG_BUFFER_LIMIT   = 2'd2
  } cfg_index_t;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

endpackage

// File: hdl/drp_own_mem.sv
module drp_own_mem #(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/descriptor_ring_producer_top.sv
// A request is accepted in S_IDLE and looked up in S_LOOKUP; its result is registered
// at the output on leaving S_LOOKUP, later only while the previous result is still stalled.
// A new request is not accepted until the previous one has left S_LOOKUP, since the
// own-bit memory read is followed by its write-back.
// Reset is synchronous; afterwards a clearing pass over all 2 * 2**clog2(RING_ENTRIES)
// own-bit addresses (1024 by default) zeroes the own bits while no request is accepted.
module descriptor_ring_producer_top
  import drp_pkg::*;
#(
  parameter int RING_ENTRIES = RING_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]      cfg_data,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   command,
  input  logic [1:0]             ring_select,
  input  logic [SLOT_W-1:0]      release_slot,
  input  logic [31:0]            buffer_address,
  input  logic [15:0]            packet_length,
  input  logic [15:0]            station_id,
  input  logic [7:0]             aggregate_count,
  input  logic [7:0]             forward_kind,
  input  logic [15:0]            original_length,
  input  logic                   last_fragment,
  input  logic [31:0]            side_info,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [1:0]             status,
  output logic [SLOT_W-1:0]      slot_used,
  output logic [31:0]            descriptor_address,
  output logic [31:0]            copy_source,
  output logic [LIMIT_W-1:0]     copy_length,
  output logic [31:0]            word_zero,
  output logic [31:0]            word_one,
  output logic [31:0]            word_two
);

  localparam int IW = $clog2(RING_ENTRIES);
  localparam int AW = IW + 1;
  localparam logic [IW:0] ENTRIES_W = (IW + 1)'(RING_ENTRIES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;

  logic [BASE_W-1:0] ring_zero_base;
  logic [BASE_W-1:0] ring_one_base;
  logic [LIMIT_W-1:0] dma_buffer_limit;

  logic [IW-1:0] write_index [2];

  logic r_command;
  logic [1:0] r_ring;
  logic [SLOT_W-1:0] r_rel;
  logic [31:0] r_buf;
  logic [15:0] r_plen;
  logic [15:0] r_sta;
  logic [7:0] r_agg;
  logic [7:0] r_fwd;
  logic [15:0] r_olen;
  logic r_last;
  logic [31:0] r_info;
  logic [IW-1:0] r_idx;

  logic accept;
  logic out_free;
  logic own_rdata;
  logic [IW-1:0] cur_idx;
  logic [IW:0] ahead_sum;
  logic [IW:0] ahead_wrap;
  logic [IW:0] idx_inc;
  logic [IW-1:0] idx_next;
  logic [31:0] rel_wide;
  logic rel_ok;
  logic [IW-1:0] rel_slot;
  logic ring_bad;
  logic do_release;
  logic do_submit;
  logic [BASE_W-1:0] base_sel;
  logic [31:0] base_forced;
  logic [31:0] addr_calc;
  logic [LIMIT_W-1:0] len_calc;
  logic [15:0] limit_wide;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [1:0] status_next;
  logic [SLOT_W-1:0] slot_next;
  logic [31:0] address_next;
  logic [31:0] source_next;
  logic [LIMIT_W-1:0] length_next;
  logic [31:0] word_zero_next;
  logic [31:0] word_one_next;
  logic [31:0] word_two_next;

  assign req_stall = (state != S_IDLE);
  assign accept = req_valid && (state == S_IDLE);
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    cur_idx = write_index[ring_select[0]];
    ahead_sum = {1'b0, cur_idx} + (IW + 1)'(2);
    if (ahead_sum >= ENTRIES_W) begin
      ahead_wrap = ahead_sum - ENTRIES_W;
    end else begin
      ahead_wrap = ahead_sum;
    end
    mem_raddr = {ring_select[0], ahead_wrap[IW-1:0]};
  end

  always_comb begin
    idx_inc = {1'b0, r_idx} + (IW + 1)'(1);
    idx_next = (idx_inc < ENTRIES_W) ? idx_inc[IW-1:0] : '0;
    rel_wide = 32'(r_rel);
    rel_ok = (rel_wide < 32'(RING_ENTRIES));
    rel_slot = rel_wide[IW-1:0];
    ring_bad = r_ring[1];
    do_release = (state == S_LOOKUP) && out_free && !ring_bad && (r_command == CMD_RELEASE);
    do_submit = (state == S_LOOKUP) && out_free && !ring_bad && (r_command == CMD_SUBMIT)
                && !own_rdata;
    base_sel = r_ring[0] ? ring_one_base : ring_zero_base;
    base_forced = {2'b01, base_sel[29:0]};
    addr_calc = base_forced + 32'({r_idx, 4'b0000}) + 32'({r_idx, 3'b000});
    limit_wide = 16'(dma_buffer_limit);
    if (r_plen <= limit_wide) begin
      len_calc = r_plen[LIMIT_W-1:0];
    end else if (r_olen > limit_wide) begin
      len_calc = dma_buffer_limit;
    end else begin
      len_calc = r_olen[LIMIT_W-1:0];
    end
    status_next = STATUS_BAD_RING;
    slot_next = '0;
    address_next = '0;
    source_next = '0;
    length_next = '0;
    word_zero_next = '0;
    word_one_next = '0;
    word_two_next = '0;
    if (!ring_bad) begin
      if (r_command == CMD_RELEASE) begin
        status_next = STATUS_RELEASED;
        slot_next = r_rel;
      end else if (own_rdata) begin
        status_next = STATUS_FULL;
        slot_next = SLOT_W'(r_idx);
      end else begin
        status_next = STATUS_WRITTEN;
        slot_next = SLOT_W'(r_idx);
        address_next = addr_calc;
        source_next = r_buf;
        length_next = len_calc;
        word_zero_next = {2'b00, r_last, r_plen[13:0], r_olen[13:0], 1'b1};
        word_one_next = {r_fwd[5:0], 5'b00000, r_agg[4:0], r_sta};
        word_two_next = r_info;
      end
    end
    mem_we = 1'b0;
    mem_waddr = {r_ring[0], r_idx};
    mem_wdata = 1'b1;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 1'b0;
    end else if (do_release) begin
      mem_we = rel_ok;
      mem_waddr = {r_ring[0], rel_slot};
      mem_wdata = 1'b0;
    end else if (do_submit) begin
      mem_we = 1'b1;
    end
  end

  drp_own_mem #(
    .ADDR_W(AW)
  ) u_own_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (own_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_zero_base <= '0;
      ring_one_base <= '0;
      dma_buffer_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RING_ZERO_BASE: ring_zero_base <= cfg_data;
        CFG_RING_ONE_BASE: ring_one_base <= cfg_data;
        CFG_BUFFER_LIMIT: dma_buffer_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_command <= command;
      r_ring <= ring_select;
      r_rel <= release_slot;
      r_buf <= buffer_address;
      r_plen <= packet_length;
      r_sta <= station_id;
      r_agg <= aggregate_count;
      r_fwd <= forward_kind;
      r_olen <= original_length;
      r_last <= last_fragment;
      r_info <= side_info;
      r_idx <= cur_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      res_valid <= 1'b0;
      write_index[0] <= '0;
      write_index[1] <= '0;
    end else begin
      if ((state == S_LOOKUP) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (out_free) begin
            state <= S_IDLE;
            status <= status_next;
            slot_used <= slot_next;
            descriptor_address <= address_next;
            copy_source <= source_next;
            copy_length <= length_next;
            word_zero <= word_zero_next;
            word_one <= word_one_next;
            word_two <= word_two_next;
            if (do_submit) begin
              write_index[r_ring[0]] <= idx_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
